>>> hw/rtl/vmmmv_pkg.sv
// shared types and constants for the volume statistics block
package vmmmv_pkg;

   // configuration port
   localparam int SIZE_BITS    = 9;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type CSR_SIZE_X = 2'd0;
   localparam csr_idx_type CSR_SIZE_Y = 2'd1;
   localparam csr_idx_type CSR_SIZE_Z = 2'd2;

   // status of the job queue between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> hw/rtl/vmmmv_req_if.sv
// input channel: one voxel sample per word
interface vmmmv_req_if #(
   parameter int SAMPLE_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

>>> hw/rtl/vmmmv_rsp_if.sv
// result channel: one statistics word per volume
interface vmmmv_rsp_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 16
) ();
   logic                                      valid;
   logic                                      ready;
   logic signed [SAMPLE_BITS-1:0]             minimum;
   logic signed [SAMPLE_BITS-1:0]             maximum;
   logic signed [SAMPLE_BITS+FRAC_BITS-1:0]   mean;
   logic        [2*SAMPLE_BITS+FRAC_BITS-2:0] variance;

   modport source (output valid, output minimum, output maximum, output mean,
                   output variance, input ready);
   modport sink   (input valid, input minimum, input maximum, input mean,
                   input variance, output ready);
endinterface

>>> hw/rtl/vmmmv_front.sv
// front end: size registers, sample squaring and per-volume accumulation
module vmmmv_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_DIM     = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  vmmmv_pkg::csr_idx_type                csr_index,
   input  logic [vmmmv_pkg::SIZE_BITS-1:0]       csr_wdata,
   vmmmv_req_if.sink                             req_bus,
   input  vmmmv_pkg::q_stat_type                 q_stat,
   output logic                                  push,
   output logic [2*SAMPLE_BITS
                 + (SAMPLE_BITS+$clog2(MAX_DIM*MAX_DIM*MAX_DIM+1))
                 + (2*SAMPLE_BITS+$clog2(MAX_DIM*MAX_DIM*MAX_DIM+1)-2)
                 + 3*$clog2(MAX_DIM*MAX_DIM*MAX_DIM+1)-1:0] job
);
   localparam int DIM_BITS = $clog2(MAX_DIM+1);
   localparam int CNT_BITS = $clog2(MAX_DIM*MAX_DIM*MAX_DIM+1);
   localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
   localparam int SQ_BITS  = 2*SAMPLE_BITS + CNT_BITS - 2;
   localparam int SQI_BITS = 2*SAMPLE_BITS - 1;
   localparam int N2_BITS  = 2*CNT_BITS;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] min_v;
      logic signed [SAMPLE_BITS-1:0] max_v;
      logic signed [SUM_BITS-1:0]    sum;
      logic        [SQ_BITS-1:0]     sumsq;
      logic        [CNT_BITS-1:0]    n;
      logic        [N2_BITS-1:0]     n2;
   } job_type;

   // size registers and derived voxel count
   logic [DIM_BITS-1:0]   sx_ff, sy_ff, sz_ff, sat_v;
   logic [2*DIM_BITS-1:0] sxy_ff, sxy_full;
   logic [3*DIM_BITS-1:0] n_full;
   logic [CNT_BITS-1:0]   n_ff;
   logic [N2_BITS-1:0]    n2_ff, n2_full;

   // square stage
   logic                          a_valid_ff, a_valid_in;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff;
   logic        [SQI_BITS-1:0]    a_sq_ff;
   logic signed [2*SAMPLE_BITS-1:0] sq_full;

   // accumulators
   logic        [CNT_BITS-1:0]    count_ff, count_in, cnt_next;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, min_new;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in, max_new;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in, sum_new;
   logic        [SQ_BITS-1:0]     sq_ff, sq_in, sq_new;

   logic    accept, a_close, a_go;
   job_type job_s;

   always_comb begin
      if (csr_wdata == '0) begin
         sat_v = DIM_BITS'(1);
      end else if (32'(csr_wdata) > 32'(MAX_DIM)) begin
         sat_v = DIM_BITS'(MAX_DIM);
      end else begin
         sat_v = DIM_BITS'(csr_wdata);
      end
   end

   assign sxy_full = sx_ff * sy_ff;
   assign n_full   = sxy_ff * sz_ff;
   assign n2_full  = n_ff * n_ff;
   assign sq_full  = req_bus.sample * req_bus.sample;

   assign cnt_next = count_ff + 1'b1;
   assign a_close  = cnt_next >= n_ff;
   assign a_go     = a_valid_ff && !(a_close && q_stat.full);
   assign req_bus.ready = !a_valid_ff || a_go;
   assign accept   = req_bus.valid && req_bus.ready;
   assign push     = a_go && a_close;

   always_comb begin
      min_new = ((count_ff == '0) || (a_sample_ff < min_ff)) ? a_sample_ff : min_ff;
      max_new = ((count_ff == '0) || (a_sample_ff > max_ff)) ? a_sample_ff : max_ff;
      sum_new = sum_ff + SUM_BITS'(a_sample_ff);
      sq_new  = sq_ff + SQ_BITS'(a_sq_ff);

      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      if (a_go) begin
         if (a_close) begin
            count_in = '0;
            min_in   = '0;
            max_in   = '0;
            sum_in   = '0;
            sq_in    = '0;
         end else begin
            count_in = cnt_next;
            min_in   = min_new;
            max_in   = max_new;
            sum_in   = sum_new;
            sq_in    = sq_new;
         end
      end

      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_comb begin
      job_s.min_v = min_new;
      job_s.max_v = max_new;
      job_s.sum   = sum_new;
      job_s.sumsq = sq_new;
      job_s.n     = n_ff;
      job_s.n2    = n2_ff;
   end
   assign job = job_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff      <= DIM_BITS'(1);
         sy_ff      <= DIM_BITS'(1);
         sz_ff      <= DIM_BITS'(1);
         sxy_ff     <= (2*DIM_BITS)'(1);
         n_ff       <= CNT_BITS'(1);
         n2_ff      <= N2_BITS'(1);
         a_valid_ff <= 1'b0;
         count_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         sum_ff     <= '0;
         sq_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               vmmmv_pkg::CSR_SIZE_X: sx_ff <= sat_v;
               vmmmv_pkg::CSR_SIZE_Y: sy_ff <= sat_v;
               vmmmv_pkg::CSR_SIZE_Z: sz_ff <= sat_v;
               default: ;
            endcase
         end
         sxy_ff     <= sxy_full;
         n_ff       <= n_full[CNT_BITS-1:0];
         n2_ff      <= n2_full;
         a_valid_ff <= a_valid_in;
         count_ff   <= count_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         sum_ff     <= sum_in;
         sq_ff      <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sample_ff <= req_bus.sample;
         a_sq_ff     <= sq_full[SQI_BITS-1:0];
      end
   end

endmodule

>>> hw/rtl/vmmmv_queue.sv
// small register fifo carrying finished volume totals to the back end
module vmmmv_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       rd_data,
   output vmmmv_pkg::q_stat_type  stat
);
   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_BITS = $clog2(DEPTH+1);

   logic [WIDTH-1:0]     entry_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FILL_BITS-1:0] fill_ff;

   assign rd_data    = entry_ff[rd_ptr_ff];
   assign stat.full  = fill_ff == FILL_BITS'(DEPTH);
   assign stat.empty = fill_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hw/rtl/vmmmv_back.sv
// back end: shift-add multiplier and restoring divider for mean and variance
module vmmmv_back #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_DIM     = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vmmmv_pkg::q_stat_type                 q_stat,
   input  logic [2*SAMPLE_BITS
                 + (SAMPLE_BITS+$clog2(MAX_DIM*MAX_DIM*MAX_DIM+1))
                 + (2*SAMPLE_BITS+$clog2(MAX_DIM*MAX_DIM*MAX_DIM+1)-2)
                 + 3*$clog2(MAX_DIM*MAX_DIM*MAX_DIM+1)-1:0] job,
   output logic                                  pop,
   vmmmv_rsp_if.source                           rsp_bus
);
   localparam int CNT_BITS  = $clog2(MAX_DIM*MAX_DIM*MAX_DIM+1);
   localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
   localparam int SQ_BITS   = 2*SAMPLE_BITS + CNT_BITS - 2;
   localparam int N2_BITS   = 2*CNT_BITS;
   localparam int MAG_BITS  = SUM_BITS - 1;
   localparam int PROD_BITS = 2*MAG_BITS;
   localparam int DIV_BITS  = PROD_BITS + FRAC_BITS;
   localparam int MEAN_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int VAR_BITS  = 2*SAMPLE_BITS + FRAC_BITS - 1;
   localparam int STEP_BITS = $clog2(DIV_BITS+1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] min_v;
      logic signed [SAMPLE_BITS-1:0] max_v;
      logic signed [SUM_BITS-1:0]    sum;
      logic        [SQ_BITS-1:0]     sumsq;
      logic        [CNT_BITS-1:0]    n;
      logic        [N2_BITS-1:0]     n2;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ADD,
      ST_MUL_SUB,
      ST_DIV_MEAN,
      ST_DIV_VAR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   job_type   job_s;

   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic                          neg_ff, neg_in;
   logic [MAG_BITS-1:0]           mag_ff, mag_in, mplier_ff, mplier_in;
   logic [SUM_BITS-1:0]           mag_full;
   logic [CNT_BITS-1:0]           n_ff, n_in;
   logic [N2_BITS-1:0]            n2_ff, n2_in, divisor;
   logic [PROD_BITS-1:0]          acc_ff, acc_in, mcand_ff, mcand_in;
   logic [DIV_BITS-1:0]           dvd_ff, dvd_in;
   logic [N2_BITS-1:0]            rem_ff, rem_in;
   logic [N2_BITS:0]              trial;
   logic                          q_bit;
   logic [VAR_BITS-1:0]           q_ff, q_in, q_new;
   logic [MEAN_BITS-1:0]          mean_ff, mean_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic                          last_step;

   logic                          out_valid_ff, out_valid_in, out_load;
   logic signed [SAMPLE_BITS-1:0] out_min_ff, out_max_ff;
   logic [MEAN_BITS-1:0]          out_mean_ff;
   logic [VAR_BITS-1:0]           out_var_ff;

   assign job_s     = job;
   assign mag_full  = job_s.sum[SUM_BITS-1] ? SUM_BITS'(-job_s.sum) : SUM_BITS'(job_s.sum);
   assign last_step = step_ff == STEP_BITS'(1);
   assign pop       = (state_ff == ST_IDLE) && !q_stat.empty;
   assign out_load  = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_bus.ready);

   // one restoring divide step
   assign divisor = (state_ff == ST_DIV_MEAN) ? N2_BITS'(n_ff) : n2_ff;
   assign trial   = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign q_bit   = trial >= {1'b0, divisor};
   assign q_new   = {q_ff[VAR_BITS-2:0], q_bit};

   always_comb begin
      state_in  = state_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      n_in      = n_ff;
      n2_in     = n2_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      mean_in   = mean_ff;
      step_in   = step_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               min_in    = job_s.min_v;
               max_in    = job_s.max_v;
               neg_in    = job_s.sum[SUM_BITS-1];
               mag_in    = mag_full[MAG_BITS-1:0];
               n_in      = job_s.n;
               n2_in     = job_s.n2;
               acc_in    = '0;
               mcand_in  = PROD_BITS'(job_s.sumsq);
               mplier_in = MAG_BITS'(job_s.n);
               step_in   = STEP_BITS'(CNT_BITS);
               state_in  = ST_MUL_ADD;
            end
         end
         ST_MUL_ADD: begin
            acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (last_step) begin
               mcand_in  = PROD_BITS'(mag_ff);
               mplier_in = mag_ff;
               step_in   = STEP_BITS'(MAG_BITS);
               state_in  = ST_MUL_SUB;
            end
         end
         ST_MUL_SUB: begin
            acc_in    = mplier_ff[0] ? acc_ff - mcand_ff : acc_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (last_step) begin
               // floor of a negative mean: divide the magnitude rounded up
               dvd_in   = (DIV_BITS'(mag_ff) << FRAC_BITS)
                        + (neg_ff ? DIV_BITS'(n_ff - 1'b1) : '0);
               rem_in   = '0;
               step_in  = STEP_BITS'(DIV_BITS);
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN, ST_DIV_VAR: begin
            rem_in  = q_bit ? N2_BITS'(trial - {1'b0, divisor}) : trial[N2_BITS-1:0];
            dvd_in  = dvd_ff << 1;
            q_in    = q_new;
            step_in = step_ff - 1'b1;
            if (last_step) begin
               if (state_ff == ST_DIV_MEAN) begin
                  mean_in  = neg_ff ? MEAN_BITS'(-q_new[MEAN_BITS-1:0])
                                    : q_new[MEAN_BITS-1:0];
                  dvd_in   = DIV_BITS'(acc_ff) << FRAC_BITS;
                  rem_in   = '0;
                  step_in  = STEP_BITS'(DIV_BITS);
                  state_in = ST_DIV_VAR;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      min_ff    <= min_in;
      max_ff    <= max_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      n_ff      <= n_in;
      n2_ff     <= n2_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      mean_ff   <= mean_in;
      step_ff   <= step_in;
      if (out_load) begin
         out_min_ff  <= min_ff;
         out_max_ff  <= max_ff;
         out_mean_ff <= mean_ff;
         out_var_ff  <= q_ff;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.minimum  = out_min_ff;
   assign rsp_bus.maximum  = out_max_ff;
   assign rsp_bus.mean     = out_mean_ff;
   assign rsp_bus.variance = out_var_ff;

endmodule

>>> hw/rtl/volume_min_max_mean_variance.sv
// top level of the volume min / max / mean / variance statistics block
// throughput: one sample word per cycle while the job queue has room; the back end works through
//   one volume at a time, bound by its bit-serial multiplier and divider
// closing sample to result: square register, job queue, back end states, output register
// reset: synchronous, active high; sizes return to 1, accumulators and queue empty
// a size write reaches the voxel count through the size register, sxy_ff and n_ff in turn
module volume_min_max_mean_variance #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_DIM     = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  vmmmv_pkg::csr_idx_type          csr_index,
   input  logic [vmmmv_pkg::SIZE_BITS-1:0] csr_wdata,
   vmmmv_req_if.sink                       req_bus,
   vmmmv_rsp_if.source                     rsp_bus
);
   // widths of one queued job: min, max, sum, sum of squares, n, n squared
   localparam int CNT_BITS = $clog2(MAX_DIM*MAX_DIM*MAX_DIM+1);
   localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
   localparam int SQ_BITS  = 2*SAMPLE_BITS + CNT_BITS - 2;
   localparam int JOB_BITS = 2*SAMPLE_BITS + SUM_BITS + SQ_BITS + 3*CNT_BITS;

   // two jobs of slack lets short volumes queue while the divider runs
   localparam int Q_DEPTH = 2;

   logic                  job_push;
   logic                  job_pop;
   logic [JOB_BITS-1:0]   job_wdata;
   logic [JOB_BITS-1:0]   job_rdata;
   vmmmv_pkg::q_stat_type q_stat;

   // front: one word a cycle, square registered, then accumulate;
   // stalls only when a volume closes against a full queue
   vmmmv_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_DIM     (MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .q_stat    (q_stat),
      .push      (job_push),
      .job       (job_wdata)
   );

   // finished volume totals wait here for the back end
   vmmmv_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wdata),
      .pop     (job_pop),
      .rd_data (job_rdata),
      .stat    (q_stat)
   );

   // back: n*sumsq - sum^2 by shift-add, then mean and variance by restoring
   // division, result held in an output register so the next job can start
   vmmmv_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_DIM     (MAX_DIM),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .job     (job_rdata),
      .pop     (job_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// testbench of the volume min / max / mean / variance block with its own statistics predictor
module tb;

   localparam int     SAMPLE_BITS  = 16;
   localparam int     FRAC_BITS    = 16;
   localparam int     MAX_DIM      = 256;
   localparam int     SIZE_BITS    = vmmmv_pkg::SIZE_BITS;
   localparam int     WORD_TARGET  = 2000;
   localparam int     MAX_IDLE     = 18;
   // wait after the last owed word, chosen to outlast one back end job
   localparam int     DRAIN_CYCLES = 300;
   // wait after a size write so that it reaches the sample path
   localparam int     CSR_SETTLE   = 3;
   localparam longint CYCLE_LIMIT  = 4000000;

   // the one index with no register behind it
   localparam vmmmv_pkg::csr_idx_type CSR_UNMAPPED = 2'd3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0]             minimum;
      logic signed [SAMPLE_BITS-1:0]             maximum;
      logic signed [SAMPLE_BITS+FRAC_BITS-1:0]   mean;
      logic        [2*SAMPLE_BITS+FRAC_BITS-2:0] variance;
   } vol_stats_type;

   // how the voxel values of one volume are spread
   typedef enum int {
      FLAT_NOISE,
      RAIL_HEAVY,
      NARROW_BAND
   } value_mix_type;

   // running statistics of the open volume plus the queue of stats words still owed
   class volume_stats_board_type;
      int unsigned   dim [3];
      int unsigned   count;
      sample_type    low_val;
      sample_type    high_val;
      longint        sum;
      logic [127:0]  sum_sq;
      vol_stats_type pending [$];
      int            errors;

      function new();
         dim      = '{1, 1, 1};
         count    = 0;
         low_val  = '0;
         high_val = '0;
         sum      = 0;
         sum_sq   = '0;
         errors   = 0;
      endfunction

      // sizes saturate into 1..MAX_DIM, unmapped index does nothing
      function void write_size(vmmmv_pkg::csr_idx_type idx, logic [SIZE_BITS-1:0] value);
         int unsigned d;
         d = value;
         if (d == 0) d = 1;
         if (d > MAX_DIM) d = MAX_DIM;
         case (idx)
            vmmmv_pkg::CSR_SIZE_X: dim[0] = d;
            vmmmv_pkg::CSR_SIZE_Y: dim[1] = d;
            vmmmv_pkg::CSR_SIZE_Z: dim[2] = d;
            default: ;
         endcase
      endfunction

      function void note_sample(sample_type s);
         logic [127:0]  n;
         logic [127:0]  mag;
         logic [127:0]  num;
         logic [127:0]  quo;
         logic [127:0]  spread;
         vol_stats_type r;
         bit            neg;
         if (count == 0 || s < low_val) low_val = s;
         if (count == 0 || s > high_val) high_val = s;
         sum    += longint'(s);
         sum_sq += 128'(longint'(s) * longint'(s));
         count++;
         n = 128'(dim[0]) * 128'(dim[1]) * 128'(dim[2]);
         // volume closes once the count reaches or passes the current size
         if (128'(count) < n) return;
         neg = (sum < 0);
         mag = neg ? 128'(-sum) : 128'(sum);
         // floor division of the signed sum
         num = mag << FRAC_BITS;
         if (neg) num = num + n - 1;
         quo = num / n;
         r.mean = neg ? -quo[SAMPLE_BITS+FRAC_BITS-1:0] : quo[SAMPLE_BITS+FRAC_BITS-1:0];
         // exact one-pass variance
         spread = sum_sq * n - mag * mag;
         quo = (spread << FRAC_BITS) / (n * n);
         r.variance = quo[2*SAMPLE_BITS+FRAC_BITS-2:0];
         r.minimum  = low_val;
         r.maximum  = high_val;
         pending.push_back(r);
         count    = 0;
         low_val  = '0;
         high_val = '0;
         sum      = 0;
         sum_sq   = '0;
      endfunction

      function void check_result(vol_stats_type got);
         vol_stats_type want;
         if (pending.size() == 0) begin
            $error("result word with none owed: minimum %0d maximum %0d mean %0d variance %0d",
                   got.minimum, got.maximum, got.mean, got.variance);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.minimum !== want.minimum) begin
            $error("minimum: expected %0d, got %0d", want.minimum, got.minimum);
            errors++;
         end
         if (got.maximum !== want.maximum) begin
            $error("maximum: expected %0d, got %0d", want.maximum, got.maximum);
            errors++;
         end
         if (got.mean !== want.mean) begin
            $error("mean: expected %0d, got %0d", want.mean, got.mean);
            errors++;
         end
         if (got.variance !== want.variance) begin
            $error("variance: expected %0d, got %0d", want.variance, got.variance);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   vmmmv_pkg::csr_idx_type csr_index;
   logic [SIZE_BITS-1:0]   csr_wdata;

   // burst phases: the side draws no idle cycles at all
   bit                     req_burst;
   bit                     rsp_burst;
   longint                 cycle_count;

   volume_stats_board_type board = new();

   vmmmv_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   vmmmv_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) rsp_bus ();

   volume_min_max_mean_variance #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_DIM    (MAX_DIM),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("volume_min_max_mean_variance verification failed");
         $finish;
      end
   end

   // every accepted result word goes against the oldest owed stats
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result('{rsp_bus.minimum, rsp_bus.maximum, rsp_bus.mean, rsp_bus.variance});
   end

   // result side: random stall per word, sometimes only once the word is already waiting
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, MAX_IDLE);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
               do @(posedge clock); while (!rsp_bus.valid);
            end
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // one voxel word; valid stays high into the next word unless an idle gap is drawn
   task automatic send_word(sample_type s);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      board.note_sample(s);
      @(negedge clock);
   endtask

   // drop valid, let owed words come out and the back end run dry
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // single register write, then hold off until it reaches the sample path
   task automatic csr_write(vmmmv_pkg::csr_idx_type idx, logic [SIZE_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_size(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
      repeat (CSR_SETTLE) @(negedge clock);
   endtask

   // size as written: now and then 0 for 1, or an oversized value for the maximum
   function automatic logic [SIZE_BITS-1:0] raw_size(int unsigned d);
      if (d == 1 && $urandom_range(0, 3) == 0) return '0;
      if (d == MAX_DIM && $urandom_range(0, 1) == 1)
         return SIZE_BITS'($urandom_range(MAX_DIM + 1, (1 << SIZE_BITS) - 1));
      return SIZE_BITS'(d);
   endfunction

   function automatic sample_type draw_sample(value_mix_type mix, sample_type center);
      sample_type rails [6];
      rails = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h8001};
      case (mix)
         RAIL_HEAVY:
            return ($urandom_range(0, 3) != 0) ? rails[$urandom_range(0, 5)]
                                              : sample_type'($urandom());
         NARROW_BAND: return center + sample_type'($urandom_range(0, 15)) - sample_type'(8);
         default:     return sample_type'($urandom());
      endcase
   endfunction

   initial begin
      int unsigned   dims [3];
      int unsigned   vol_words;
      int unsigned   n_words;
      int            words_sent;
      int            big_axis;
      bit            big;
      value_mix_type mix;
      sample_type    center;

      csr_we         = 1'b0;
      csr_index      = vmmmv_pkg::CSR_SIZE_X;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      req_burst      = 1'b0;
      rsp_burst      = 1'b0;
      cycle_count    = 0;
      words_sent     = 0;
      big_axis       = 0;
      mix            = FLAT_NOISE;
      center         = '0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // single voxel volumes at reset sizes: one result per word, zero variance
      send_word(16'h0000);
      send_word(16'hffff);
      send_word(16'h7fff);
      send_word(16'h8000);
      send_word(16'h0001);
      send_word(16'h5555);

      // two voxel volumes at the rails: largest spread, then flat at each rail
      wait_quiet();
      csr_write(vmmmv_pkg::CSR_SIZE_X, 9'd2);
      send_word(16'h8000);
      send_word(16'h7fff);
      send_word(16'h7fff);
      send_word(16'h7fff);
      send_word(16'h8000);
      send_word(16'h8000);

      // zero size written reads as one; negative sum checks floor on the mean
      wait_quiet();
      csr_write(vmmmv_pkg::CSR_SIZE_X, 9'd0);
      csr_write(vmmmv_pkg::CSR_SIZE_Y, 9'd3);
      send_word(-16'sd5);
      send_word(16'sd7);
      send_word(-16'sd3);

      // unmapped write ignored, oversized sizes clamp, then the volume shrinks
      // under an open one so the next word closes it past the new size
      wait_quiet();
      csr_write(CSR_UNMAPPED, 9'h1ff);
      csr_write(vmmmv_pkg::CSR_SIZE_Z, 9'h1ff);
      csr_write(vmmmv_pkg::CSR_SIZE_Y, 9'd300);
      send_word(16'h1234);
      send_word(16'hedcb);
      wait_quiet();
      csr_write(vmmmv_pkg::CSR_SIZE_Y, 9'd1);
      csr_write(vmmmv_pkg::CSR_SIZE_Z, 9'd1);
      send_word(16'h0100);

      // random phases: mostly small volumes sent whole, a few full-length axes,
      // sometimes a volume left open across a size change
      while (words_sent < WORD_TARGET) begin
         wait_quiet();
         big = ($urandom_range(0, 14) == 0);
         if (big) begin
            dims = '{1, 1, 1};
            dims[big_axis] = MAX_DIM;
            big_axis = (big_axis + 1) % 3;
         end else begin
            dims[0] = $urandom_range(1, 6);
            dims[1] = $urandom_range(1, 4);
            dims[2] = $urandom_range(1, 3);
         end
         if ($urandom_range(0, 5) == 0) csr_write(CSR_UNMAPPED, SIZE_BITS'($urandom()));
         csr_write(vmmmv_pkg::CSR_SIZE_X, raw_size(dims[0]));
         csr_write(vmmmv_pkg::CSR_SIZE_Y, raw_size(dims[1]));
         csr_write(vmmmv_pkg::CSR_SIZE_Z, raw_size(dims[2]));

         vol_words = dims[0] * dims[1] * dims[2];
         n_words   = (big ? 1 : $urandom_range(1, 4)) * vol_words;
         if (vol_words > 1 && $urandom_range(0, 4) == 0)
            n_words += $urandom_range(1, vol_words - 1);

         req_burst = ($urandom_range(0, 4) == 0);
         rsp_burst = ($urandom_range(0, 4) == 0);

         for (int k = 0; k < n_words; k++) begin
            // fresh value spread at each nominal volume start
            if (k % vol_words == 0) begin
               mix    = value_mix_type'($urandom_range(0, 2));
               center = sample_type'($urandom());
            end
            send_word(draw_sample(mix, center));
         end
         words_sent += n_words;
      end

      wait_quiet();
      if (board.errors == 0)
         $display("volume_min_max_mean_variance verification clean");
      else
         $display("volume_min_max_mean_variance verification failed");
      $finish;
   end

endmodule

>>> volume_min_max_mean_variance.f
hw/rtl/vmmmv_pkg.sv
hw/rtl/vmmmv_req_if.sv
hw/rtl/vmmmv_rsp_if.sv
hw/rtl/vmmmv_front.sv
hw/rtl/vmmmv_queue.sv
hw/rtl/vmmmv_back.sv
hw/rtl/volume_min_max_mean_variance.sv
test/tb.sv
